/* sv/bbat_pkg.sv */
// ============================================================================
// bbat_pkg
// Shared types, codes and the helper function of the banked bump allocator and
// handle translator.
// ============================================================================
package bbat_pkg;

  // Field widths of the stream beats.
  localparam int COUNT_W  = 14;
  localparam int BYTES_W  = 14;
  localparam int HANDLE_W = 10;
  localparam int INDEX_W  = 16;
  localparam int BANK_W   = 8;
  localparam int ADDR_W   = 16;
  localparam int ERR_W    = 3;

  // Packed beat widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Shared arithmetic unit widths.
  localparam int SHIFT_W = 4;
  localparam int DATA_W  = 30;

  // Command codes carried on tuser.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_LARGE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_OUT_BOUNDS = 3'd2;
  localparam logic [ERR_W-1:0] ERR_EXHAUSTED  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_HANDLE = 3'd4;

  // Control of the shared unit for one step.
  typedef struct packed {
    logic               sub;
    logic [SHIFT_W-1:0] shamt;
  } alu_ctl_t;

  // Smallest e with 2^e >= bytes; zero for sizes of zero or one.
  function automatic logic [SHIFT_W-1:0] ceil_log2(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W-1:0] v;
    logic [SHIFT_W-1:0] r;
    v = bytes - BYTES_W'(1);
    r = '0;
    if (bytes > BYTES_W'(1)) begin
      for (int i = 0; i < BYTES_W; i++) begin
        if (v[i]) begin
          r = SHIFT_W'(i + 1);
        end
      end
    end
    return r;
  endfunction

endpackage

/* sv/bbat_alu.sv */
// ============================================================================
// bbat_alu
// Shared add/subtract unit with borrow flag, and the shared left shifter.
// ============================================================================
module bbat_alu
  import bbat_pkg::*;
(
  input  alu_ctl_t            ctl,
  input  logic [DATA_W-1:0]   a,
  input  logic [DATA_W-1:0]   b,
  output logic [DATA_W-1:0]   result,
  output logic                borrow,
  input  logic [INDEX_W-1:0]  shift_in,
  output logic [DATA_W-1:0]   shift_out
);

  logic [DATA_W-1:0] b_op;
  logic              carry;

  // Subtraction as a plus the complement of b plus one; no carry out is a borrow.
  assign b_op              = ctl.sub ? ~b : b;
  assign {carry, result}   = {1'b0, a} + {1'b0, b_op} + {{DATA_W{1'b0}}, ctl.sub};
  assign borrow            = ctl.sub & ~carry;

  assign shift_out = DATA_W'(shift_in) << ctl.shamt;

endmodule

/* sv/banked_bump_allocator_translator.sv */
// ============================================================================
// banked_bump_allocator_translator
// Bump allocator over banked memory with a handle table, and a translator
// from handle and element index to bank and windowed address.
// ============================================================================
// The block takes one command beat at a time and answers each with exactly
// one result beat. An allocate command (tuser low) rounds the element size up
// to a power of two, sizes the block, carves it from the current bank or opens
// the next bank at offset zero, records it under the next handle and returns
// that handle with its bank and windowed address. A translate command (tuser
// high) checks a handle and an element index and returns the bank, the
// windowed address of the element and the recorded element size. Every step
// of the arithmetic goes through one shared adder and shifter under a small
// sequencer, and the handle table is a synchronous memory with a registered
// read. An allocate passes the states shift, size check, sum, fit and address
// before its result beat, and a translate the states read, check, base and
// address. s_tready is low from acceptance until the result beat has been
// taken, also while that beat waits for m_tready, so no new command is taken
// before the last result has gone. Handles are issued in order from one, so
// the table needs no valid bits and no clearing pass: a handle is live exactly
// when it is non-zero and below the next handle to be issued. Any error returns
// zeros in every field but the error code and leaves the state untouched.
module banked_bump_allocator_translator
  import bbat_pkg::*;
#(
  parameter int BANK_BYTES  = 8192,
  parameter int WINDOW_BASE = 40960,
  parameter int TABLE_BANK  = 1,
  parameter int MAX_HANDLES = 1024,
  parameter int LAST_BANK   = 255
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // element_count [13:0], element_bytes [27:14], handle [37:28],
  // element_index [53:38], zero fill [55:54]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // new_handle [9:0], bank [17:10], address [33:18], size_bytes [47:34],
  // error [50:48], zero fill [55:51]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Widths that follow from the parameters.
  localparam int NW = $clog2(MAX_HANDLES + 1);  // next handle, may equal MAX_HANDLES
  localparam int HW = $clog2(MAX_HANDLES);      // table index
  localparam int OW = $clog2(BANK_BYTES + 1);   // offset, may equal BANK_BYTES

  typedef struct packed {
    logic [BANK_W-1:0]  bank;
    logic [OW-1:0]      offset;
    logic [COUNT_W-1:0] count;
    logic [BYTES_W-1:0] size;
    logic [SHIFT_W-1:0] shift;
  } entry_t;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_SHIFT = 4'd1;
  localparam logic [3:0] S_A_BIG   = 4'd2;
  localparam logic [3:0] S_A_SUM   = 4'd3;
  localparam logic [3:0] S_A_FIT   = 4'd4;
  localparam logic [3:0] S_A_ADDR  = 4'd5;
  localparam logic [3:0] S_T_READ  = 4'd6;
  localparam logic [3:0] S_T_CHK   = 4'd7;
  localparam logic [3:0] S_T_BASE  = 4'd8;
  localparam logic [3:0] S_T_ADDR  = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0]             state;

  // Captured command.
  logic [COUNT_W-1:0]     count_r;
  logic [BYTES_W-1:0]     bytes_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic [INDEX_W-1:0]     index_r;

  // Working registers of the sequence.
  logic [SHIFT_W-1:0]     shift_r;
  logic [DATA_W-1:0]      total_r;   // block size, or the shifted index
  logic [DATA_W-1:0]      sum_r;     // end of block, or base plus offset
  logic                   too_big;
  logic                   fits;
  logic                   in_range;
  logic                   bad_handle;

  // Allocation state.
  logic [NW-1:0]          next_handle;
  logic [BANK_W-1:0]      open_bank;
  logic [OW-1:0]          bump_offset;

  // Handle table.
  entry_t                 table_mem [MAX_HANDLES];
  entry_t                 rd_entry;
  logic [HW-1:0]          rd_addr;
  logic                   wr_en;
  entry_t                 wr_entry;

  logic [OUT_TDATA_W-1:0] out_data;

  // Shared unit.
  alu_ctl_t               alu_ctl;
  logic [DATA_W-1:0]      alu_a;
  logic [DATA_W-1:0]      alu_b;
  logic [DATA_W-1:0]      alu_res;
  logic                   alu_borrow;
  logic [INDEX_W-1:0]     shift_in;
  logic [DATA_W-1:0]      shift_out;

  // Allocate decisions of the final step.
  logic [ERR_W-1:0]       alloc_err;
  logic [BANK_W-1:0]      alloc_bank;
  logic [OW-1:0]          alloc_offset;
  logic [ERR_W-1:0]       xlate_err;

  bbat_alu u_alu (
    .ctl       (alu_ctl),
    .a         (alu_a),
    .b         (alu_b),
    .result    (alu_res),
    .borrow    (alu_borrow),
    .shift_in  (shift_in),
    .shift_out (shift_out)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = out_data;
  assign rd_addr  = HW'(handle_r);

  // Operand selection for the shared unit, one operation per state.
  always_comb begin
    alu_ctl  = '0;
    alu_a    = '0;
    alu_b    = '0;
    shift_in = '0;
    case (state)
      S_A_SHIFT: begin
        shift_in      = INDEX_W'(count_r);
        alu_ctl.shamt = ceil_log2(bytes_r);
      end
      S_A_BIG: begin
        alu_ctl.sub = 1'b1;
        alu_a       = DATA_W'(BANK_BYTES);
        alu_b       = total_r;
      end
      S_A_SUM: begin
        alu_a = DATA_W'(bump_offset);
        alu_b = total_r;
      end
      S_A_FIT: begin
        alu_ctl.sub = 1'b1;
        alu_a       = DATA_W'(BANK_BYTES);
        alu_b       = sum_r;
      end
      S_A_ADDR: begin
        alu_a = DATA_W'(WINDOW_BASE);
        alu_b = fits ? DATA_W'(bump_offset) : '0;
      end
      S_T_CHK: begin
        alu_ctl.sub   = 1'b1;
        alu_ctl.shamt = rd_entry.shift;
        alu_a         = DATA_W'(index_r);
        alu_b         = DATA_W'(rd_entry.count);
        shift_in      = index_r;
      end
      S_T_BASE: begin
        alu_a = DATA_W'(WINDOW_BASE);
        alu_b = DATA_W'(rd_entry.offset);
      end
      S_T_ADDR: begin
        alu_a = sum_r;
        alu_b = total_r;
      end
      default: begin
        alu_ctl = '0;
      end
    endcase
  end

  // Final allocate decision: size first, then handles, then banks. A new
  // bank is refused once the open bank has reached the last one.
  always_comb begin
    alloc_bank   = fits ? open_bank : open_bank + BANK_W'(1);
    alloc_offset = fits ? bump_offset : '0;
    if (too_big) begin
      alloc_err = ERR_TOO_LARGE;
    end else if (next_handle >= NW'(MAX_HANDLES)) begin
      alloc_err = ERR_EXHAUSTED;
    end else if (!fits && (open_bank >= BANK_W'(LAST_BANK))) begin
      alloc_err = ERR_EXHAUSTED;
    end else begin
      alloc_err = ERR_OK;
    end
    if (bad_handle) begin
      xlate_err = ERR_BAD_HANDLE;
    end else if (!in_range) begin
      xlate_err = ERR_OUT_BOUNDS;
    end else begin
      xlate_err = ERR_OK;
    end
    wr_en          = (state == S_A_ADDR) && (alloc_err == ERR_OK);
    wr_entry.bank   = alloc_bank;
    wr_entry.offset = alloc_offset;
    wr_entry.count  = count_r;
    wr_entry.size   = bytes_r;
    wr_entry.shift  = shift_r;
  end

  // Handle table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[HW'(next_handle)] <= wr_entry;
    end
    rd_entry <= table_mem[rd_addr];
  end

  // Sequencer and allocation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      next_handle <= NW'(1);
      open_bank   <= BANK_W'(TABLE_BANK + 1);
      bump_offset <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == CMD_XLATE) ? S_T_READ : S_A_SHIFT;
          end
        end
        S_A_SHIFT: state <= S_A_BIG;
        S_A_BIG:   state <= S_A_SUM;
        S_A_SUM:   state <= S_A_FIT;
        S_A_FIT:   state <= S_A_ADDR;
        S_A_ADDR: begin
          state <= S_OUT;
          if (alloc_err == ERR_OK) begin
            next_handle <= next_handle + NW'(1);
            open_bank   <= alloc_bank;
            bump_offset <= fits ? sum_r[OW-1:0] : total_r[OW-1:0];
          end
        end
        S_T_READ:  state <= S_T_CHK;
        S_T_CHK:   state <= S_T_BASE;
        S_T_BASE:  state <= S_T_ADDR;
        S_T_ADDR:  state <= S_OUT;
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        count_r  <= s_tdata[13:0];
        bytes_r  <= s_tdata[27:14];
        handle_r <= s_tdata[37:28];
        index_r  <= s_tdata[53:38];
      end
      S_A_SHIFT: begin
        total_r <= shift_out;
        shift_r <= alu_ctl.shamt;
      end
      S_A_BIG: too_big <= alu_borrow;
      S_A_SUM: sum_r   <= alu_res;
      S_A_FIT: fits    <= ~alu_borrow;
      S_A_ADDR: begin
        if (alloc_err == ERR_OK) begin
          out_data <= OUT_TDATA_W'({ERR_OK, bytes_r, alu_res[ADDR_W-1:0], alloc_bank,
                                    HANDLE_W'(next_handle)});
        end else begin
          out_data <= OUT_TDATA_W'({alloc_err, 48'd0});
        end
      end
      S_T_CHK: begin
        in_range   <= ~index_r[INDEX_W-1] & alu_borrow;
        total_r    <= shift_out;
        bad_handle <= (handle_r == '0) || (32'(handle_r) >= 32'(next_handle));
      end
      S_T_BASE: sum_r <= alu_res;
      S_T_ADDR: begin
        if (xlate_err == ERR_OK) begin
          out_data <= OUT_TDATA_W'({ERR_OK, rd_entry.size, alu_res[ADDR_W-1:0],
                                    rd_entry.bank, HANDLE_W'(0)});
        end else begin
          out_data <= OUT_TDATA_W'({xlate_err, 48'd0});
        end
      end
      default: begin
        out_data <= out_data;
      end
    endcase
  end

  // The block never takes a command while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("command accepted while a result is pending");

  // Once a result beat has gone, the block is free for the next command.
  a_free_after_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready)
    else $error("block not free after result beat");

  // Handles are issued one at a time and never run past the table.
  a_handle_step: assert property (@(posedge clk) disable iff (rst)
    ##1 ((next_handle == $past(next_handle)) ||
         (next_handle == $past(next_handle) + NW'(1))))
    else $error("next handle moved by more than one");

  a_handle_range: assert property (@(posedge clk) disable iff (rst)
    (next_handle != '0) && (next_handle <= NW'(MAX_HANDLES)))
    else $error("next handle out of range");

  // The bump pointer stays within its bank, and only the bank opened at
  // reset may lie past the last bank.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (32'(bump_offset) <= 32'(BANK_BYTES)) &&
    ((32'(open_bank) <= 32'(LAST_BANK)) || (open_bank == BANK_W'(TABLE_BANK + 1))))
    else $error("bump pointer outside its bank");

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the banked bump allocator and handle translator.
// ============================================================================
// Command beats go in on the slave-side stream and result beats are checked
// as they leave the master-side stream. A small tracker class keeps its own
// copy of the handle table, the next handle and the bump pointer. It works
// out the answer to every accepted command and checks the result beats
// against those answers in order.
//
// The run has three parts. A short directed part comes first: handle zero,
// unissued handles, empty blocks, exact fits, blocks too large by one,
// all-ones sizes and the edges of the index range. A random part follows,
// mostly allocations and translations of live handles, with some noise, and
// random idling on both sides. A final part, with no idling, opens banks
// until they run out, so that bank exhaustion is seen.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbat_pkg::*;

  // Block configuration, kept in step with the instance below.
  localparam int unsigned BANK_B   = 8192;
  localparam int unsigned WIN_BASE = 40960;
  localparam int unsigned TABLE_B  = 1;
  localparam int unsigned MAX_H    = 1024;
  localparam int unsigned LAST_B   = 255;

  // A generous limit on the length of the run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 500000;

  // One result beat, laid out as on m_tdata: the first field in the lowest
  // bits, so it sits last in the packed struct.
  typedef struct packed {
    logic [4:0]          fill;
    logic [ERR_W-1:0]    error;
    logic [BYTES_W-1:0]  size_bytes;
    logic [ADDR_W-1:0]   address;
    logic [BANK_W-1:0]   bank;
    logic [HANDLE_W-1:0] new_handle;
  } result_t;

  // What the table holds for one handle.
  typedef struct packed {
    logic [BANK_W-1:0]  bank;
    logic [13:0]        offset;
    logic [COUNT_W-1:0] count;
    logic [BYTES_W-1:0] size;
    logic [3:0]         shift;
  } block_rec_t;

  // Tracks the allocator state and the answers still owed by the block.
  class alloc_tracker;
    block_rec_t   blocks [MAX_H];
    bit           live [MAX_H];
    int unsigned  next_h;
    int unsigned  cur_bank;
    int unsigned  cur_off;
    result_t      answers_due [$];
    logic [ERR_W-1:0] last_err;
    int unsigned  n_alloc;
    int unsigned  n_xlate;
    int unsigned  n_checked;
    int unsigned  fail_count;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      next_h     = 1;
      cur_bank   = TABLE_B + 1;
      cur_off    = 0;
      last_err   = ERR_OK;
      n_alloc    = 0;
      n_xlate    = 0;
      n_checked  = 0;
      fail_count = 0;
    endfunction

    // Exponent of the smallest power of two that holds the element.
    function int unsigned size_shift(int unsigned bytes);
      int unsigned sh;
      sh = 0;
      while (sh < 31 && (32'd1 << sh) < bytes) sh++;
      return sh;
    endfunction

    // Works out the answer to an accepted command and updates the state.
    function void note_command(logic cmd, logic [COUNT_W-1:0] count,
                               logic [BYTES_W-1:0] bytes, logic [HANDLE_W-1:0] h,
                               logic [INDEX_W-1:0] idx);
      result_t     want;
      int unsigned sh;
      int unsigned total;
      int unsigned bank;
      int unsigned off;
      want = '0;
      if (cmd == CMD_ALLOC) begin
        n_alloc++;
        sh    = size_shift(32'(bytes));
        total = 32'(count) << sh;
        bank  = cur_bank;
        off   = cur_off;
        // The size check wins over both kinds of exhaustion.
        if (total > BANK_B) begin
          want.error = ERR_TOO_LARGE;
        end else if (next_h >= MAX_H) begin
          want.error = ERR_EXHAUSTED;
        end else begin
          if (BANK_B - off < total) begin
            bank++;
            off = 0;
          end
          if (bank > LAST_B) begin
            want.error = ERR_EXHAUSTED;
          end else begin
            blocks[next_h].bank   = 8'(bank);
            blocks[next_h].offset = 14'(off);
            blocks[next_h].count  = count;
            blocks[next_h].size   = bytes;
            blocks[next_h].shift  = 4'(sh);
            live[next_h]    = 1'b1;
            cur_bank        = bank;
            cur_off         = off + total;
            want.new_handle = 10'(next_h);
            want.bank       = 8'(bank);
            want.address    = 16'(WIN_BASE + off);
            want.size_bytes = bytes;
            next_h++;
          end
        end
      end else begin
        n_xlate++;
        if (h == 0 || 32'(h) >= MAX_H || !live[h]) begin
          want.error = ERR_BAD_HANDLE;
        end else if (idx[INDEX_W-1] || 32'(idx) >= 32'(blocks[h].count)) begin
          want.error = ERR_OUT_BOUNDS;
        end else begin
          want.bank       = blocks[h].bank;
          want.address    = 16'(WIN_BASE + 32'(blocks[h].offset) +
                                (32'(idx) << blocks[h].shift));
          want.size_bytes = blocks[h].size;
        end
      end
      last_err = want.error;
      answers_due.push_back(want);
    endfunction

    task mismatch(string what);
      $display("MISMATCH at result beat %0d: %s", n_checked, what);
      fail_count++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Checks one result beat against the oldest answer owed.
    task check_result(logic [OUT_TDATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = beat;
      if (answers_due.size() == 0) begin
        mismatch($sformatf("beat 0x%0h arrived with no command outstanding", beat));
      end else begin
        want = answers_due.pop_front();
        compare_field("new_handle", 16'(got.new_handle), 16'(want.new_handle));
        compare_field("bank", 16'(got.bank), 16'(want.bank));
        compare_field("address", got.address, want.address);
        compare_field("size_bytes", 16'(got.size_bytes), 16'(want.size_bytes));
        compare_field("error", 16'(got.error), 16'(want.error));
        compare_field("zero fill", 16'(got.fill), 16'(want.fill));
      end
      n_checked++;
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // element_count [13:0], element_bytes [27:14], handle [37:28],
  // element_index [53:38], zero fill [55:54]
  logic [IN_TDATA_W-1:0]  s_tdata;
  // command [0]
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  // new_handle [9:0], bank [17:10], address [33:18], size_bytes [47:34],
  // error [50:48], zero fill [55:51]
  logic [OUT_TDATA_W-1:0] m_tdata;

  alloc_tracker tracker = new();

  // Chance, in per cent, that an idle burst starts before a command beat or
  // on a given cycle of the receiving side.
  int unsigned src_gap_pct  = 0;
  int unsigned sink_gap_pct = 0;
  int unsigned cycle_count  = 0;

  banked_bump_allocator_translator #(
    .BANK_BYTES  (BANK_B),
    .WINDOW_BASE (WIN_BASE),
    .TABLE_BANK  (TABLE_B),
    .MAX_HANDLES (MAX_H),
    .LAST_BANK   (LAST_B)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, tracker.answers_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result beats are taken at the rising edge, where m_tvalid and m_tdata
  // still hold the values that the handshake sees.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // The receiving side stalls in random bursts. Each cycle gets at most one
  // assignment to m_tready, made at the falling edge.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Presents one command beat from a falling edge and holds it until it is
  // accepted. On return the bench stands at the falling edge after the
  // accepting edge with s_tvalid still high, so that the next beat, or an
  // idle burst, replaces it with a single assignment.
  task send_command(input logic cmd, input logic [COUNT_W-1:0] count,
                    input logic [BYTES_W-1:0] bytes, input logic [HANDLE_W-1:0] h,
                    input logic [INDEX_W-1:0] idx);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, idx, h, bytes, count};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_command(cmd, count, bytes, h, idx);
    @(negedge clk);
  endtask

  // The fields that a command does not use carry random values, so that the
  // block is seen to ignore them.
  task alloc_cmd(input logic [COUNT_W-1:0] count, input logic [BYTES_W-1:0] bytes);
    send_command(CMD_ALLOC, count, bytes, HANDLE_W'($urandom), INDEX_W'($urandom));
  endtask

  task xlate_cmd(input logic [HANDLE_W-1:0] h, input logic [INDEX_W-1:0] idx);
    send_command(CMD_XLATE, COUNT_W'($urandom), BYTES_W'($urandom), h, idx);
  endtask

  // Allocation with mostly modest sizes, plus exact fits, blocks one
  // element too large and raw random fields.
  task random_alloc();
    int unsigned r;
    int unsigned bytes;
    int unsigned count;
    int unsigned fit;
    r = $urandom_range(0, 99);
    if (r < 10)      bytes = 0;
    else if (r < 50) bytes = $urandom_range(1, 16);
    else if (r < 70) bytes = 1 << $urandom_range(0, 13);
    else if (r < 90) bytes = $urandom_range(1, BANK_B);
    else             bytes = $urandom_range(0, 16383);
    // Largest count that still fits a bank at this element size.
    fit = BANK_B >> tracker.size_shift(bytes);
    r = $urandom_range(0, 99);
    if (r < 8)                     count = 0;
    else if (r < 60)               count = $urandom_range(1, 16);
    else if (r < 75 && fit > 0)    count = $urandom_range(1, fit);
    else if (r < 85 && fit > 0)    count = fit;
    else if (r < 92 && fit > 0)    count = fit + 1;
    else                           count = $urandom_range(0, 16383);
    alloc_cmd(COUNT_W'(count), BYTES_W'(bytes));
  endtask

  // Translation of a live handle, with indices inside the block, at its
  // edges, negative and raw.
  task xlate_live();
    int unsigned r;
    int unsigned h;
    int unsigned c;
    logic [INDEX_W-1:0] idx;
    h = $urandom_range(1, tracker.next_h - 1);
    c = tracker.blocks[h].count;
    r = $urandom_range(0, 99);
    if (c != 0 && r < 60)      idx = INDEX_W'($urandom_range(0, c - 1));
    else if (c != 0 && r < 70) idx = INDEX_W'(c - 1);
    else if (r < 80)           idx = INDEX_W'(c);
    else if (r < 90)           idx = {1'b1, 15'($urandom)};
    else                       idx = INDEX_W'($urandom);
    xlate_cmd(HANDLE_W'(h), idx);
  endtask

  task random_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      random_alloc();
    end else if (r < 90 && tracker.next_h > 1) begin
      xlate_live();
    end else if (r < 95) begin
      // Noise: any handle at all, mostly unissued ones.
      xlate_cmd(HANDLE_W'($urandom), INDEX_W'($urandom));
    end else begin
      xlate_cmd('0, INDEX_W'($urandom));
    end
  endtask

  initial begin
    logic [HANDLE_W-1:0] h_empty;
    logic [HANDLE_W-1:0] h_small;
    logic [HANDLE_W-1:0] h_whole;
    logic [HANDLE_W-1:0] h_big;
    logic [HANDLE_W-1:0] h_pair;
    logic [HANDLE_W-1:0] h_five;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with light idling on both sides.
    src_gap_pct  = 10;
    sink_gap_pct = 5;
    xlate_cmd(0, 0);                 // handle zero belongs to the table
    xlate_cmd(1, 0);                 // not issued yet
    h_empty = HANDLE_W'(tracker.next_h);
    alloc_cmd(0, 0);                 // empty block of zero-byte elements
    xlate_cmd(h_empty, 0);           // every index into it is out of bounds
    alloc_cmd(1, 1);
    h_small = HANDLE_W'(tracker.next_h);
    alloc_cmd(3, 3);                 // three bytes round up to four
    xlate_cmd(h_small, 2);
    xlate_cmd(h_small, 3);           // index equal to the count
    xlate_cmd(h_small, 16'hFFFF);    // minus one
    xlate_cmd(h_small, 16'h8000);    // most negative index
    h_whole = HANDLE_W'(tracker.next_h);
    alloc_cmd(8192, 1);              // a whole bank: opens the next one
    alloc_cmd(8193, 1);              // one byte too large
    h_big = HANDLE_W'(tracker.next_h);
    alloc_cmd(1, 8192);              // largest element, bank full again
    alloc_cmd(2, 8192);              // too large
    alloc_cmd(16383, 16383);         // all ones in both fields
    alloc_cmd(1, 8193);              // rounds up past a bank
    alloc_cmd(0, 16383);             // empty block at the very end of a bank
    h_pair = HANDLE_W'(tracker.next_h);
    alloc_cmd(4096, 2);
    xlate_cmd(h_pair, 4095);         // last element of a full bank
    xlate_cmd(h_big, 0);
    xlate_cmd(1023, 0);              // highest handle, never issued here
    xlate_cmd(h_whole, 8191);
    xlate_cmd(h_whole, 16'h7FFF);    // largest positive index
    h_five = HANDLE_W'(tracker.next_h);
    alloc_cmd(5, 5);
    xlate_cmd(h_five, 4);

    // Random part in stretches of fifty beats, each with its own idling
    // on either side: none, light or heavy.
    for (int blk = 0; blk < 6; blk++) begin
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 10;
        default: src_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: sink_gap_pct = 0;
        1: sink_gap_pct = 5;
        default: sink_gap_pct = 25;
      endcase
      repeat (50) random_command();
    end

    // Final part at full rate. Whole-bank blocks open banks until the banks
    // run out.
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    alloc_cmd(1, 8192);
    while (tracker.last_err != ERR_EXHAUSTED) alloc_cmd(1, 8192);
    alloc_cmd(1, 1);                 // no bank left even for one byte
    alloc_cmd(0, 0);                 // an empty block still fits the full last bank
    alloc_cmd(16383, 16383);         // the size check still comes first
    repeat (20) xlate_live();
    xlate_cmd(1023, 0);              // highest handle, still unissued

    s_tvalid <= 1'b0;
    while (tracker.answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d commands: %0d allocates and %0d translates, %0d result beats checked.",
             tracker.n_alloc + tracker.n_xlate, tracker.n_alloc, tracker.n_xlate,
             tracker.n_checked);
    $display("Issued %0d handles, reaching bank %0d; %0d mismatches.",
             tracker.next_h - 1, tracker.cur_bank, tracker.fail_count);
    if (tracker.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bbat_pkg.sv
sv/bbat_alu.sv
sv/banked_bump_allocator_translator.sv
tb/tb_top.sv
